// ===== rtl/core/bsm_pkg.sv =====
// Package for the bounded set membership block: field widths, request codes
// and parameter defaults. No dependencies.
package bsm_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_ELEM_WIDTH = 32;

    localparam int REQ_W   = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

endpackage

// ===== rtl/core/bsm_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on bsm_pkg.
interface bsm_req_if
    import bsm_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] elem_value;

    modport source (output valid, output req_type, output elem_value, input ready);
    modport sink   (input valid, input req_type, input elem_value, output ready);
endinterface

interface bsm_rsp_if
    import bsm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               op_success;
    logic               full_reject;
    logic [COUNT_W-1:0] element_count;
    logic               set_empty;

    modport source (output valid, output op_success, output full_reject,
                    output element_count, output set_empty, input ready);
    modport sink   (input valid, input op_success, input full_reject,
                    input element_count, input set_empty, output ready);
endinterface

// ===== rtl/core/bsm_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/bounded_set_membership.sv =====
// Channel | modport | beat carries
// req     | sink    | req_type, elem_value
// rsp     | source  | op_success, full_reject, element_count, set_empty
//
// A request is accepted in ST_IDLE, scanned slot by slot from the slot RAM
// (the scan stops at a match), then decided and written back in ST_DECIDE.
// After reset a clearing pass zeroes every slot of the slot RAM; no request
// is taken meanwhile. A result waits in the output register while the next
// request is accepted and scanned; only write-back waits for rsp.ready.
// Depends on bsm_pkg, bsm_if and bsm_ram.
module bounded_set_membership
    import bsm_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    bsm_req_if.sink    req,
    bsm_rsp_if.source  rsp
);

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KEY_W   = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;
    localparam int ENTRY_W = KEY_W + 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [REQ_W-1:0]   req_type_reg, req_type_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic               ok_reg, ok_next;
    logic               full_reg, full_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               empty_reg, empty_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic                     slot_valid;
    logic                     slot_match;
    logic                     decide_go;
    logic [CNT_W-1:0]         cnt_after;

    bsm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_valid = ram_rdata[KEY_W];
    assign slot_match = slot_valid && (ram_rdata[KEY_W-1:0] == key_reg);
    assign decide_go  = (state_reg == ST_DECIDE) && (!out_valid_reg || rsp.ready);

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.op_success    = ok_reg;
    assign rsp.full_reject   = full_reg;
    assign rsp.element_count = out_count_reg;
    assign rsp.set_empty     = empty_reg;

    assign ram_raddr = (state_reg == ST_SCAN) ? IDX_W'(idx_reg + 1'b1) : '0;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        req_type_next  = req_type_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        full_next      = full_reg;
        out_count_next = out_count_reg;
        empty_next     = empty_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = '0;
        cnt_after      = count_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '0;
                idx_next  = IDX_W'(idx_reg + 1'b1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    req_type_next = req.req_type;
                    key_next      = req.elem_value[KEY_W-1:0];
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    idx_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!slot_valid && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (slot_match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                end
                idx_next = IDX_W'(idx_reg + 1'b1);
                if (slot_match || (idx_reg == LAST_IDX))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (decide_go)
                begin
                    ok_next   = 1'b0;
                    full_next = 1'b0;
                    case (req_type_reg)
                        REQ_ADD:
                        begin
                            if (!hit_reg)
                            begin
                                if (free_reg)
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = free_idx_reg;
                                    ram_wdata = {1'b1, key_reg};
                                    cnt_after = CNT_W'(count_reg + 1'b1);
                                    ok_next   = 1'b1;
                                end
                                else
                                begin
                                    full_next = 1'b1;
                                end
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = hit_idx_reg;
                                ram_wdata = {1'b0, key_reg};
                                if (count_reg != '0)
                                begin
                                    cnt_after = CNT_W'(count_reg - 1'b1);
                                end
                                ok_next = 1'b1;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            ok_next = hit_reg;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                    count_next     = cnt_after;
                    out_count_next = COUNT_W'(cnt_after);
                    empty_next     = (cnt_after == '0);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg  <= req_type_next;
        key_reg       <= key_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        ok_reg        <= ok_next;
        full_reg      <= full_next;
        out_count_reg <= out_count_next;
        empty_reg     <= empty_next;
    end

endmodule
